// File: rtl/core/ook_frame_byte_transmitter_defines.svh
// Assertion macros for the framed byte transmitter.
// Used by the top level; expects clk and arst_n in scope.
`ifndef OOK_FRAME_BYTE_TRANSMITTER_DEFINES_SVH
`define OOK_FRAME_BYTE_TRANSMITTER_DEFINES_SVH

// checked only outside reset
`define OFBT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked during reset as well
`define OFBT_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/ofbt_pkg.sv
// Shared types and constants for the framed byte transmitter.
// No dependencies.
`timescale 1ns / 1ps

package ofbt_pkg;

	localparam int STEP_W = 4;              // up to 13 words per request
	localparam int PRE_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam int LEN_W = 16;
	localparam int WORD_W = 10;

	localparam logic [7:0] PREAMBLE_OCTET = 8'hAA;
	localparam logic [PRE_W-1:0] MAX_PREAMBLE = 4'd8;
	localparam logic [PRE_W-1:0] PREAMBLE_RESET = 4'd4;
	localparam logic [7:0] SYNC_RESET = 8'h7E;

	localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE = 2'd1;

	typedef enum logic [2:0] {
		KIND_PREAMBLE = 3'd0,
		KIND_SYNC     = 3'd1,
		KIND_LENGTH   = 3'd2,
		KIND_PAYLOAD  = 3'd3,
		KIND_CHECKSUM = 3'd4
	} kind_t;

	typedef struct packed {
		logic [7:0]       data;
		logic             first;
		logic             final_mark;
		logic [LEN_W-1:0] len;
	} item_t;

	typedef struct packed {
		logic [7:0] octet;
		kind_t      kind;
		logic       last;
	} word_t;

endpackage

// File: rtl/core/ofbt_word_gen.sv
// Picks the octet, kind and end mark for one step of a request's word run.
// Depends on ofbt_pkg.
`timescale 1ns / 1ps

module ofbt_word_gen (
	input  ofbt_pkg::item_t                  item,
	input  logic [ofbt_pkg::STEP_W-1:0]      step,
	input  logic [ofbt_pkg::PRE_W-1:0]       pre_count,
	input  logic [7:0]                       sync_value,
	input  logic [7:0]                       xor_base,
	output ofbt_pkg::word_t                  word
);
	import ofbt_pkg::*;

	logic [PRE_W-1:0] pre_sat;
	logic [4:0]       pre5;
	logic [4:0]       k5;
	logic [4:0]       hdr;
	logic [4:0]       nwords;
	logic             has_pay;
	logic [7:0]       csum;

	always_comb begin
		pre_sat = (pre_count > MAX_PREAMBLE) ? MAX_PREAMBLE : pre_count;
		pre5 = {1'b0, pre_sat};
		k5 = {1'b0, step};
		// empty frame: header and checksum only
		has_pay = !(item.first && item.final_mark && (item.len == '0));
		hdr = item.first ? (pre5 + 5'd3) : 5'd0;
		nwords = hdr + {4'd0, has_pay} + {4'd0, item.final_mark};
		csum = xor_base ^ (has_pay ? item.data : 8'h00);

		word.last = (k5 == (nwords - 5'd1));
		priority if (item.first && (k5 < pre5)) begin
			word.octet = PREAMBLE_OCTET;
			word.kind = KIND_PREAMBLE;
		end else if (item.first && (k5 == pre5)) begin
			word.octet = sync_value;
			word.kind = KIND_SYNC;
		end else if (item.first && (k5 == (pre5 + 5'd1))) begin
			word.octet = item.len[15:8];
			word.kind = KIND_LENGTH;
		end else if (item.first && (k5 == (pre5 + 5'd2))) begin
			word.octet = item.len[7:0];
			word.kind = KIND_LENGTH;
		end else if (has_pay && (k5 == hdr)) begin
			word.octet = item.data;
			word.kind = KIND_PAYLOAD;
		end else begin
			word.octet = csum;
			word.kind = KIND_CHECKSUM;
		end
	end

endmodule

// File: rtl/core/ofbt_out_stage.sv
// Output register for line words; holds a word while the sink stalls.
// Depends on ofbt_pkg.
`timescale 1ns / 1ps

module ofbt_out_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  ofbt_pkg::word_t               word,
	output logic                          take,
	output logic                          word_valid,
	input  logic                          word_stall,
	output logic [ofbt_pkg::WORD_W-1:0]   line_word,
	output logic [7:0]                    frame_octet,
	output logic [2:0]                    octet_kind,
	output logic                          last_of_run
);
	import ofbt_pkg::*;

	logic  valid_q;
	word_t word_q;

	assign take = !valid_q || !word_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (take && load) begin
			word_q <= word;
		end
	end

	assign word_valid = valid_q;
	// start bit high, data MSB first, stop bit low
	assign line_word = {1'b1, word_q.octet, 1'b0};
	assign frame_octet = word_q.octet;
	assign octet_kind = word_q.kind;
	assign last_of_run = word_q.last;

endmodule

// File: rtl/core/ook_frame_byte_transmitter.sv
// Framed byte transmitter top level: input register, frame state, config.
// Depends on ofbt_pkg, ofbt_word_gen, ofbt_out_stage and the defines header.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  item    | item_valid/item_stall  | data_byte first_byte final_byte frame_length
//  word    | word_valid/word_stall  | line_word frame_octet octet_kind last_of_run
//  cfg     | cfg_valid/cfg_ready    | cfg_index cfg_data
//
// One line word leaves per cycle while word_stall is low; a request gives
// 1 word for a middle byte, 2 for a last one, min(preamble_count, 8) + 4 for
// a first (+1 with checksum, except an empty frame, which has no payload word).
// A byte outside a frame is consumed and gives no word.
// item_stall rises while the input register still has words to send;
// word_stall on a held word holds back the rest of the run.
// arst_n clears valid bits, step counter and frame state; config gets its defaults.
`timescale 1ns / 1ps
`include "ook_frame_byte_transmitter_defines.svh"

module ook_frame_byte_transmitter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [7:0]                        data_byte,
	input  logic                              first_byte,
	input  logic                              final_byte,
	input  logic [ofbt_pkg::LEN_W-1:0]        frame_length,
	output logic                              word_valid,
	input  logic                              word_stall,
	output logic [ofbt_pkg::WORD_W-1:0]       line_word,
	output logic [7:0]                        frame_octet,
	output logic [2:0]                        octet_kind,
	output logic                              last_of_run,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ofbt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ofbt_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import ofbt_pkg::*;

	logic              valid_s1;
	item_t             item_s1;
	logic [STEP_W-1:0] step_q;
	logic [7:0]        xor_q;
	logic              inside_q;
	logic [PRE_W-1:0]  pre_count_q;
	logic [7:0]        sync_q;

	logic        item_accept;
	logic        drop;
	logic        take;
	logic        fire;
	logic        finish;
	logic [7:0]  xor_base;
	word_t       word;
	logic        fire_csum;
	logic        fire_pre;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_count_q <= PREAMBLE_RESET;
			sync_q <= SYNC_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PREAMBLE_COUNT: pre_count_q <= cfg_data[PRE_W-1:0];
				CFG_SYNC_VALUE:     sync_q <= cfg_data;
				default:            ;
			endcase
		end
	end

	// byte with no open frame is consumed silently
	assign drop = valid_s1 && !item_s1.first && !inside_q;
	assign fire = valid_s1 && !drop && take;
	assign finish = drop || (fire && word.last);
	assign item_stall = valid_s1 && !finish;
	assign item_accept = item_valid && !item_stall;
	assign xor_base = item_s1.first ? 8'h00 : xor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_accept) begin
			valid_s1 <= 1'b1;
		end else if (finish) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			item_s1 <= '{data: data_byte, first: first_byte, final_mark: final_byte,
				len: frame_length};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			xor_q <= 8'h00;
			inside_q <= 1'b0;
		end else if (fire) begin
			if (word.last) begin
				step_q <= '0;
				if (item_s1.final_mark) begin
					xor_q <= 8'h00;
					inside_q <= 1'b0;
				end else begin
					// not final, so the byte is payload
					xor_q <= xor_base ^ item_s1.data;
					inside_q <= 1'b1;
				end
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	ofbt_word_gen u_gen (
		.item       (item_s1),
		.step       (step_q),
		.pre_count  (pre_count_q),
		.sync_value (sync_q),
		.xor_base   (xor_base),
		.word       (word)
	);

	ofbt_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (fire),
		.word        (word),
		.take        (take),
		.word_valid  (word_valid),
		.word_stall  (word_stall),
		.line_word   (line_word),
		.frame_octet (frame_octet),
		.octet_kind  (octet_kind),
		.last_of_run (last_of_run)
	);

	assign fire_csum = fire && (word.kind == KIND_CHECKSUM);
	assign fire_pre = fire && (word.kind == KIND_PREAMBLE);

	`OFBT_ASSERT(a_step_bound, (step_q < 4'd13), "word step past longest run")
	`OFBT_ASSERT(a_csum_closes, fire_csum |=> !inside_q, "frame still open after checksum")
	`OFBT_ASSERT(a_preamble_first, fire_pre |-> item_s1.first, "preamble outside a first request")
	`OFBT_ASSERT_ALWAYS(a_step_idle, (!valid_s1) |-> (step_q == '0), "step counter not cleared")

endmodule
